[hdl/irs_pkg.sv]
// Package for the image rescaler: register indexes, field widths, operation and state codes.
// Used by every design module of the rescaler; depends on nothing.
package irs_pkg;

  localparam int ColW   = 7;
  localparam int RowW   = 7;
  localparam int AddrW  = ColW + RowW;
  localparam int MaxSrc = 128;
  localparam int SrcW   = 8;
  localparam int TgtW   = 12;
  localparam int FracW  = 8;
  // Dividend for the shared divider: 12-bit coordinate times 8-bit size, shifted by FracW.
  localparam int NumW   = TgtW + SrcW + FracW;
  localparam int CntW   = 5;

  localparam logic [2:0] RegSrcWidth  = 3'd0;
  localparam logic [2:0] RegSrcHeight = 3'd1;
  localparam logic [2:0] RegTgtWidth  = 3'd2;
  localparam logic [2:0] RegTgtHeight = 3'd3;
  localparam logic [2:0] RegFilter    = 3'd4;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIVX_GO, ST_DIVX, ST_DIVY_GO, ST_DIVY, ST_ADDR,
    ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_BLEND, ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic write_px;
    logic div_start;
    logic div_sel_y;
    logic div_save_x;
    logic div_save_y;
    logic make_addr;
    logic [1:0] rd_sel;
    logic rd_en;
    logic [1:0] save_sel;
    logic save_en;
    logic blend;
    logic out_load;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic is_query;
  } stat_t;

endpackage

[hdl/image_rescaler_nearest_bilinear_top.sv]
// Top level of the image rescaler: joins the controller and the datapath.
// Depends on irs_pkg, irs_ctrl, irs_dp.
//
// Input channel (in_valid/in_ready) carries one transaction: operation 0 loads
// pixel_in at (src_col, src_row) of the 128x128 frame store, operation 1 queries
// target pixel (dst_col, dst_row). Each query gives one output transaction on
// out_valid/out_ready; loads give none.
// A load passes through ST_DIVX_GO, which writes the pixel, and back to idle.
// For a query the shared restoring divider yields 28 quotient bits for each of
// the two coordinate mappings, then the single store port reads the four
// neighbors one per cycle before a two-step blend. Results appear in the output
// register, and out_valid rises together with in_ready as the controller idles.
// The output register holds one finished result, so the next query starts while
// the receiver stalls; a second result waits for the register to empty.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at once; the user must
// make them only while the block is idle; the block does not enforce this.
// Reset (rst, synchronous) restores the register defaults and empties the
// pipeline; the frame store keeps no reset value.
module image_rescaler_nearest_bilinear_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [6:0]  src_col,
  input  logic [6:0]  src_row,
  input  logic [31:0] pixel_in,
  input  logic [11:0] dst_col,
  input  logic [11:0] dst_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_out,
  output logic [11:0] out_col,
  output logic [11:0] out_row
);

  irs_pkg::ctrl_t ctrl;
  irs_pkg::stat_t stat;

  irs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .ctrl(ctrl), .stat(stat)
  );

  irs_dp u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .operation(operation), .src_col(src_col), .src_row(src_row), .pixel_in(pixel_in),
    .dst_col(dst_col), .dst_row(dst_row), .pixel_out(pixel_out), .out_col(out_col),
    .out_row(out_row), .ctrl(ctrl), .stat(stat)
  );

endmodule

[hdl/irs_div.sv]
// Radix-2 restoring divider shared by the x and y coordinate mapping, one quotient bit a cycle.
// Depends on irs_pkg.
module irs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [irs_pkg::NumW-1:0]   num,
  input  logic [irs_pkg::TgtW-1:0]   den,
  output logic [irs_pkg::NumW-1:0]   quo,
  output logic                       done
);

  logic [irs_pkg::NumW-1:0] rem_q;
  logic [irs_pkg::TgtW:0]   part;
  logic [irs_pkg::CntW-1:0] cnt;
  logic                     busy;
  logic [irs_pkg::TgtW:0]   trial;
  logic [irs_pkg::TgtW:0]   diff;

  // Shift in one dividend bit and try the subtraction.
  always_comb begin
    trial = {part[irs_pkg::TgtW-1:0], rem_q[irs_pkg::NumW-1]};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= irs_pkg::CntW'(irs_pkg::NumW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= num;
      part  <= '0;
      quo   <= '0;
    end else if (busy) begin
      rem_q <= {rem_q[irs_pkg::NumW-2:0], 1'b0};
      if (!diff[irs_pkg::TgtW]) begin
        part <= diff;
        quo  <= {quo[irs_pkg::NumW-2:0], 1'b1};
      end else begin
        part <= trial;
        quo  <= {quo[irs_pkg::NumW-2:0], 1'b0};
      end
    end
  end

endmodule

[hdl/irs_ctrl.sv]
// Controller state machine of the rescaler: sequences loads, divisions, store reads and blend.
// Depends on irs_pkg.
module irs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output irs_pkg::ctrl_t  ctrl,
  input  irs_pkg::stat_t  stat
);

  irs_pkg::state_t state, state_next;
  logic            out_full, out_full_next;

  // The output register frees the next query while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= irs_pkg::ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  assign in_ready  = (state == irs_pkg::ST_IDLE);
  assign out_valid = out_full;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      irs_pkg::ST_IDLE:    if (in_valid) state_next = irs_pkg::ST_DIVX_GO;
      irs_pkg::ST_DIVX_GO: state_next = stat.is_query ? irs_pkg::ST_DIVX : irs_pkg::ST_IDLE;
      irs_pkg::ST_DIVX:    if (stat.div_done) state_next = irs_pkg::ST_DIVY_GO;
      irs_pkg::ST_DIVY_GO: state_next = irs_pkg::ST_DIVY;
      irs_pkg::ST_DIVY:    if (stat.div_done) state_next = irs_pkg::ST_ADDR;
      irs_pkg::ST_ADDR:    state_next = irs_pkg::ST_RD0;
      irs_pkg::ST_RD0:     state_next = irs_pkg::ST_RD1;
      irs_pkg::ST_RD1:     state_next = irs_pkg::ST_RD2;
      irs_pkg::ST_RD2:     state_next = irs_pkg::ST_RD3;
      irs_pkg::ST_RD3:     state_next = irs_pkg::ST_RD4;
      irs_pkg::ST_RD4:     state_next = irs_pkg::ST_BLEND;
      irs_pkg::ST_BLEND:   state_next = irs_pkg::ST_OUT;
      irs_pkg::ST_OUT:     if (!out_full || out_ready) state_next = irs_pkg::ST_IDLE;
      default:             state_next = irs_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    ctrl          = '0;
    out_full_next = out_full && !out_ready;
    unique case (state)
      irs_pkg::ST_IDLE:    ctrl.capture = in_valid;
      irs_pkg::ST_DIVX_GO: begin
        ctrl.write_px  = !stat.is_query;
        ctrl.div_start = stat.is_query;
      end
      irs_pkg::ST_DIVX:    ctrl.div_save_x = stat.div_done;
      irs_pkg::ST_DIVY_GO: begin
        ctrl.div_start = 1'b1;
        ctrl.div_sel_y = 1'b1;
      end
      irs_pkg::ST_DIVY:    begin
        ctrl.div_sel_y  = 1'b1;
        ctrl.div_save_y = stat.div_done;
      end
      irs_pkg::ST_ADDR:    ctrl.make_addr = 1'b1;
      irs_pkg::ST_RD0:     begin
        ctrl.rd_en = 1'b1; ctrl.rd_sel = 2'd0;
      end
      irs_pkg::ST_RD1:     begin
        ctrl.rd_en = 1'b1; ctrl.rd_sel = 2'd1;
        ctrl.save_en = 1'b1; ctrl.save_sel = 2'd0;
      end
      irs_pkg::ST_RD2:     begin
        ctrl.rd_en = 1'b1; ctrl.rd_sel = 2'd2;
        ctrl.save_en = 1'b1; ctrl.save_sel = 2'd1;
      end
      irs_pkg::ST_RD3:     begin
        ctrl.rd_en = 1'b1; ctrl.rd_sel = 2'd3;
        ctrl.save_en = 1'b1; ctrl.save_sel = 2'd2;
      end
      irs_pkg::ST_RD4:     begin
        ctrl.save_en = 1'b1; ctrl.save_sel = 2'd3;
      end
      irs_pkg::ST_BLEND:   ctrl.blend = 1'b1;
      irs_pkg::ST_OUT:     if (!out_full || out_ready) begin
        ctrl.out_load = 1'b1;
        out_full_next = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[hdl/irs_dp.sv]
// Datapath of the rescaler: config registers, frame store, coordinate mapping and blend.
// Depends on irs_pkg and irs_div.
module irs_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [11:0]             cfg_data,
  input  logic                    operation,
  input  logic [irs_pkg::ColW-1:0] src_col,
  input  logic [irs_pkg::RowW-1:0] src_row,
  input  logic [31:0]             pixel_in,
  input  logic [irs_pkg::TgtW-1:0] dst_col,
  input  logic [irs_pkg::TgtW-1:0] dst_row,
  output logic [31:0]             pixel_out,
  output logic [irs_pkg::TgtW-1:0] out_col,
  output logic [irs_pkg::TgtW-1:0] out_row,
  input  irs_pkg::ctrl_t          ctrl,
  output irs_pkg::stat_t          stat
);

  localparam int FW = irs_pkg::FracW;
  localparam int SW = irs_pkg::SrcW;
  localparam int TW = irs_pkg::TgtW;

  logic [SW-1:0] src_width, src_height;
  logic [TW-1:0] target_width, target_height;
  logic          filter_mode;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= SW'(1);
      src_height    <= SW'(1);
      target_width  <= TW'(1);
      target_height <= TW'(1);
      filter_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irs_pkg::RegSrcWidth:  src_width     <= cfg_data[SW-1:0];
        irs_pkg::RegSrcHeight: src_height    <= cfg_data[SW-1:0];
        irs_pkg::RegTgtWidth:  target_width  <= cfg_data;
        irs_pkg::RegTgtHeight: target_height <= cfg_data;
        irs_pkg::RegFilter:    filter_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective sizes with the out-of-range codes folded in.
  logic [SW-1:0] sw, sh;
  logic [TW-1:0] tw, th;
  always_comb begin
    sw = (src_width == '0) ? SW'(1) : (src_width > SW'(irs_pkg::MaxSrc)) ?
         SW'(irs_pkg::MaxSrc) : src_width;
    sh = (src_height == '0) ? SW'(1) : (src_height > SW'(irs_pkg::MaxSrc)) ?
         SW'(irs_pkg::MaxSrc) : src_height;
    tw = (target_width == '0) ? TW'(1) : target_width;
    th = (target_height == '0) ? TW'(1) : target_height;
  end

  // Captured transaction.
  logic                     op_q;
  logic [irs_pkg::AddrW-1:0] waddr;
  logic [31:0]              wdata;
  logic [TW-1:0]            qx, qy;
  logic                     div_done;
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      op_q  <= operation;
      waddr <= {src_row, src_col};
      wdata <= pixel_in;
      qx    <= (dst_col > tw - 1'b1) ? tw - 1'b1 : dst_col;
      qy    <= (dst_row > th - 1'b1) ? th - 1'b1 : dst_row;
    end
  end
  assign stat = '{div_done: div_done, is_query: (op_q == irs_pkg::OpQuery)};

  // Divider operands: nearest uses t*src/tgt, bilinear uses (t*(src-1)<<F)/(tgt-1).
  logic [TW-1:0]            t_sel, tg_sel;
  logic [SW-1:0]            s_sel;
  logic [TW+SW-1:0]         prod;
  logic [irs_pkg::NumW-1:0] num;
  logic [TW-1:0]            den;
  logic                     tgt_one;
  always_comb begin
    t_sel   = ctrl.div_sel_y ? qy : qx;
    s_sel   = ctrl.div_sel_y ? sh : sw;
    tg_sel  = ctrl.div_sel_y ? th : tw;
    tgt_one = (tg_sel == TW'(1));
    if (filter_mode) begin
      prod = t_sel * (s_sel - 1'b1);
      num  = {prod, {FW{1'b0}}};
      den  = tgt_one ? TW'(1) : tg_sel - 1'b1;
    end else begin
      prod = t_sel * s_sel;
      num  = irs_pkg::NumW'(prod);
      den  = tg_sel;
    end
    if (filter_mode && tgt_one) num = '0;
  end

  logic [irs_pkg::NumW-1:0] quo;
  irs_div u_div (
    .clk(clk), .rst(rst), .start(ctrl.div_start), .num(num), .den(den),
    .quo(quo), .done(div_done)
  );

  logic [irs_pkg::NumW-1:0] posx, posy;
  always_ff @(posedge clk) begin
    if (ctrl.div_save_x) posx <= quo;
    if (ctrl.div_save_y) posy <= quo;
  end

  // Neighbor coordinates, clamped to the source frame.
  logic [irs_pkg::NumW-1:0] ix, iy;
  logic [SW-1:0]            x0, y0, x1, y1;
  logic [FW-1:0]            fx, fy;
  always_ff @(posedge clk) begin
    if (ctrl.make_addr) begin
      x0 <= (ix > irs_pkg::NumW'(sw - 1'b1)) ? sw - 1'b1 : ix[SW-1:0];
      y0 <= (iy > irs_pkg::NumW'(sh - 1'b1)) ? sh - 1'b1 : iy[SW-1:0];
      fx <= filter_mode ? posx[FW-1:0] : '0;
      fy <= filter_mode ? posy[FW-1:0] : '0;
    end
  end
  // Nearest mode reads the one selected source pixel for all four neighbors.
  always_comb begin
    ix = filter_mode ? (posx >> FW) : posx;
    iy = filter_mode ? (posy >> FW) : posy;
    x1 = !filter_mode ? x0 : (x0 + 1'b1 > sw - 1'b1) ? sw - 1'b1 : x0 + 1'b1;
    y1 = !filter_mode ? y0 : (y0 + 1'b1 > sh - 1'b1) ? sh - 1'b1 : y0 + 1'b1;
  end

  // Frame store: one write or one read a cycle, registered read data.
  logic [31:0] mem [irs_pkg::MaxSrc*irs_pkg::MaxSrc];
  logic [31:0] rdata;
  logic [SW-1:0] rx, ry;
  always_comb begin
    rx = ctrl.rd_sel[0] ? x1 : x0;
    ry = ctrl.rd_sel[1] ? y1 : y0;
  end
  always_ff @(posedge clk) begin
    if (ctrl.write_px) mem[waddr] <= wdata;
    if (ctrl.rd_en) rdata <= mem[{ry[irs_pkg::RowW-1:0], rx[irs_pkg::ColW-1:0]}];
  end

  logic [31:0] p00, p10, p01, p11;
  always_ff @(posedge clk) begin
    if (ctrl.save_en) begin
      case (ctrl.save_sel)
        2'd0:    p00 <= rdata;
        2'd1:    p10 <= rdata;
        2'd2:    p01 <= rdata;
        default: p11 <= rdata;
      endcase
    end
  end

  // Horizontal blend, registered, then vertical blend into the result.
  logic [FW:0]        wx1, wy1;
  logic [FW+7:0]      top [4];
  logic [FW+7:0]      bot [4];
  logic [2*FW+8:0]    vsum [4];
  logic [31:0]        blended;
  always_comb begin
    wx1 = (FW+1)'(1 << FW) - fx;
    wy1 = (FW+1)'(1 << FW) - fy;
    for (int c = 0; c < 4; c++) begin
      vsum[c] = top[c] * wy1 + bot[c] * fy;
      blended[c*8 +: 8] = vsum[c][2*FW +: 8];
    end
  end
  always_ff @(posedge clk) begin
    if (ctrl.save_en && ctrl.save_sel == 2'd3) begin
      for (int c = 0; c < 4; c++) begin
        top[c] <= (FW+8)'(p00[c*8 +: 8] * wx1 + p10[c*8 +: 8] * fx);
        bot[c] <= (FW+8)'(p01[c*8 +: 8] * wx1 + rdata[c*8 +: 8] * fx);
      end
    end
  end

  logic [31:0] res;
  always_ff @(posedge clk) begin
    if (ctrl.blend) res <= blended;
    if (ctrl.out_load) begin
      pixel_out <= res;
      out_col   <= qx;
      out_row   <= qy;
    end
  end

endmodule

[hdl/irs_checker.sv]
// Port-level checker for the image rescaler, bound to the top level.
// Depends on image_rescaler_nearest_bilinear_top only through its ports.
module irs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pixel_out
);

  // A result that waits is held steady.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out))
    else $error("result changed while stalled");

  // The block never accepts in the cycle right after an accepted transaction.
  a_no_back: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after acceptance");

  // A load leaves no result behind it.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !operation && !out_valid |=> !out_valid)
    else $error("result after a load");

  // Nothing is valid right after reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind image_rescaler_nearest_bilinear_top irs_checker u_irs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .operation(operation), .out_valid(out_valid), .out_ready(out_ready),
  .pixel_out(pixel_out)
);
